/* rtl/assert_macros.svh */
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that an antecedent implies a property at the same clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that an antecedent implies a property at the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/cpsp_pkg.sv */
// ----------------------------------------------------------------------------
// cpsp_pkg
// Types and constants for the cascaded position/speed PID block.
// ----------------------------------------------------------------------------
package cpsp_pkg;

   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned INTEG_WIDTH  = 48;
   localparam int unsigned GAIN_WIDTH   = 16;
   localparam int unsigned GAINS_WIDTH  = 48;
   localparam int unsigned LIMIT_WIDTH  = 31;
   localparam int unsigned RPM_WIDTH    = 16;
   localparam int unsigned CSR_IDX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 48;
   localparam int unsigned ACC_WIDTH    = 56;
   // Q16.16 values; the rpm scaling below is sized for this
   localparam int unsigned FRACTION_BITS = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LOOP_MODE      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INNER_GAINS    = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OUTER_GAINS    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INNER_OUT_LIM  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INNER_INT_LIM  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OUTER_DER_LIM  = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEADBAND       = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_OUTER_P,
      ST_OUTER_I,
      ST_OUTER_D,
      ST_OUTER_SUM,
      ST_INNER_ERR,
      ST_INNER_P,
      ST_INNER_I,
      ST_INNER_D,
      ST_INNER_SUM,
      ST_DONE
   } cpsp_state_type;

   // Datapath steps issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_SETUP,
      OP_OUTER_P,
      OP_OUTER_I,
      OP_OUTER_D,
      OP_OUTER_SUM,
      OP_INNER_ERR,
      OP_INNER_P,
      OP_INNER_I,
      OP_INNER_D,
      OP_INNER_SUM
   } cpsp_op_type;

   typedef struct packed {
      cpsp_op_type op;
      logic        load;
   } cpsp_cmd_type;

   typedef struct packed {
      logic cascade;
      logic dead;
   } cpsp_status_type;

endpackage

/* rtl/cpsp_if.sv */
// ----------------------------------------------------------------------------
// cpsp_req_if / cpsp_rsp_if / cpsp_csr_if
// Valid/ready channels of the cascaded PID block.
// ----------------------------------------------------------------------------
interface cpsp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] speed_setpoint;
   logic signed [31:0] position_setpoint;
   logic signed [31:0] measured_angle;
   logic signed [15:0] measured_rpm;
   modport source (output valid, speed_setpoint, position_setpoint, measured_angle,
      measured_rpm, input ready);
   modport sink (input valid, speed_setpoint, position_setpoint, measured_angle,
      measured_rpm, output ready);
endinterface

interface cpsp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive_value;
   logic               in_deadband;
   modport source (output valid, drive_value, in_deadband, input ready);
   modport sink (input valid, drive_value, in_deadband, output ready);
endinterface

interface cpsp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/cascaded_position_speed_pid.sv */
// ----------------------------------------------------------------------------
// cascaded_position_speed_pid
// Cascaded position/speed PID controller, one drive value per control tick.
// ----------------------------------------------------------------------------
// A tick runs setup, then in cascade mode the outer P, I, D and sum steps (only
// outer P inside the deadband, which goes straight to the result), then the inner
// error, P, I, D and sum steps; the result is held until it is taken, and the
// next tick is taken the cycle after the result beat. One shared gain multiplier
// does one gain product per cycle. Configuration writes are taken at any time
// and must come while idle.
module cascaded_position_speed_pid
   import cpsp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   cpsp_req_if.sink    req,
   cpsp_rsp_if.source  rsp,
   cpsp_csr_if.sink    csr
);

   cpsp_cmd_type    cmd;
   cpsp_status_type status;

   assign csr.ready = 1'b1;

   cpsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpsp_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr.valid),
      .csr_index         (csr.index),
      .csr_data          (csr.data),
      .speed_setpoint    (req.speed_setpoint),
      .position_setpoint (req.position_setpoint),
      .measured_angle    (req.measured_angle),
      .measured_rpm      (req.measured_rpm),
      .drive_value       (rsp.drive_value),
      .in_deadband       (rsp.in_deadband)
   );

endmodule

/* rtl/cpsp_ctrl.sv */
// ----------------------------------------------------------------------------
// cpsp_ctrl
// Sequencer stepping one tick through outer and inner PID operations.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cpsp_ctrl
   import cpsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  cpsp_status_type status,
   output cpsp_cmd_type    cmd
);

   cpsp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      cmd.load  = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.op   = OP_SETUP;
            state_in = status.cascade ? ST_OUTER_P : ST_INNER_ERR;
         end
         ST_OUTER_P: begin
            cmd.op = OP_OUTER_P;
            // drop straight to the result inside the deadband
            if (status.dead) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_OUTER_I;
            end
         end
         ST_OUTER_I: begin
            cmd.op = OP_OUTER_I;
            state_in = ST_OUTER_D;
         end
         ST_OUTER_D: begin
            cmd.op = OP_OUTER_D;
            state_in = ST_OUTER_SUM;
         end
         ST_OUTER_SUM: begin
            cmd.op = OP_OUTER_SUM;
            state_in = ST_INNER_ERR;
         end
         ST_INNER_ERR: begin
            cmd.op = OP_INNER_ERR;
            state_in = ST_INNER_P;
         end
         ST_INNER_P: begin
            cmd.op = OP_INNER_P;
            state_in = ST_INNER_I;
         end
         ST_INNER_I: begin
            cmd.op = OP_INNER_I;
            state_in = ST_INNER_D;
         end
         ST_INNER_D: begin
            cmd.op = OP_INNER_D;
            state_in = ST_INNER_SUM;
         end
         ST_INNER_SUM: begin
            cmd.op = OP_INNER_SUM;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_IMPLY(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_load_setup, clock, reset, req_valid && req_ready, state_ff == ST_SETUP)

endmodule

/* rtl/cpsp_datapath.sv */
// ----------------------------------------------------------------------------
// cpsp_datapath
// Registers, state and one shared gain multiplier for the PID arithmetic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cpsp_datapath
   import cpsp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cpsp_cmd_type              cmd,
   output cpsp_status_type           status,
   input  logic                      csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data,
   input  logic signed [31:0]        speed_setpoint,
   input  logic signed [31:0]        position_setpoint,
   input  logic signed [31:0]        measured_angle,
   input  logic signed [15:0]        measured_rpm,
   output logic signed [31:0]        drive_value,
   output logic                      in_deadband
);

   localparam logic signed [63:0] I32_MAX = 64'sh7FFF_FFFF;
   localparam logic signed [63:0] I32_MIN = -64'sh8000_0000;
   localparam logic signed [63:0] I48_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam logic signed [63:0] I48_MIN = -64'sh8000_0000_0000;
   // Reciprocal of 60 scaled by 2^36, rounded up; exact over the whole rpm
   // range at 16 fraction bits.
   localparam logic [31:0] RECIP60 = 32'd1145324613;
   localparam int unsigned RSH = 36;

   logic                     mode_ff;
   logic [GAINS_WIDTH-1:0]   igain_ff, ogain_ff;
   logic [LIMIT_WIDTH-1:0]   olim_ff, ilim_ff, dlim_ff, dband_ff;

   logic signed [31:0] sp_ff, pos_ff, ang_ff;
   logic signed [15:0] rpm_ff;
   logic signed [31:0] lim_ff;         // |speed_setpoint| saturated
   logic signed [31:0] target_ff;      // inner setpoint
   logic signed [31:0] oerr_ff, operr_ff, ierr_ff, iperr_ff;
   logic signed [47:0] oint_ff, iint_ff;
   logic signed [31:0] meas_ff;
   logic signed [41:0] p_ff, d_ff;
   logic signed [31:0] drive_ff;
   logic               dead_ff;

   // signed product gain * value shifted right by 8, value up to 33 bits
   function automatic logic signed [63:0] gmul(input logic [15:0] g,
                                              input logic signed [32:0] v);
      logic signed [63:0] pr;
      pr = $signed({1'b0, g}) * v;
      return pr >>> 8;
   endfunction

   function automatic logic signed [63:0] clampsym(input logic signed [63:0] v,
                                                  input logic signed [63:0] l);
      logic signed [63:0] r;
      if (v > l) r = l;
      else if (v < -l) r = -l;
      else r = v;
      return r;
   endfunction

   logic signed [63:0] perr, oerr_sat, ierr_sat, abs_e, sp64;
   logic signed [63:0] oint_sum, iint_sum, rpm_sc, mq;
   logic [15:0]        gsel;
   logic signed [32:0] msel;
   logic signed [63:0] prod;

   always_comb begin
      sp64     = 64'(sp_ff);
      perr     = 64'(pos_ff) - 64'(ang_ff);
      oerr_sat = (perr > I32_MAX) ? I32_MAX : ((perr < I32_MIN) ? I32_MIN : perr);
      ierr_sat = 64'(target_ff) - 64'(meas_ff);
      ierr_sat = (ierr_sat > I32_MAX) ? I32_MAX : ((ierr_sat < I32_MIN) ? I32_MIN : ierr_sat);
      abs_e    = (oerr_ff < 0) ? -64'(oerr_ff) : 64'(oerr_ff);
      gsel = 16'd0;
      msel = 33'sd0;
      case (cmd.op)
         OP_OUTER_P: begin gsel = ogain_ff[15:0];  msel = 33'(oerr_ff); end
         OP_OUTER_I: begin gsel = ogain_ff[31:16]; msel = 33'(oerr_ff); end
         OP_OUTER_D: begin
            gsel = ogain_ff[47:32];
            msel = 33'(oerr_ff) - 33'(operr_ff);
         end
         OP_INNER_P: begin gsel = igain_ff[15:0];  msel = 33'(ierr_ff); end
         OP_INNER_I: begin gsel = igain_ff[31:16]; msel = 33'(ierr_ff); end
         OP_INNER_D: begin
            gsel = igain_ff[47:32];
            msel = 33'(ierr_ff) - 33'(iperr_ff);
         end
         default: ;
      endcase
      prod = gmul(gsel, msel);
      // saturate integrators to 48 bits, inner one then to its limit
      oint_sum = 64'(oint_ff) + prod;
      oint_sum = (oint_sum > I48_MAX) ? I48_MAX : ((oint_sum < I48_MIN) ? I48_MIN : oint_sum);
      iint_sum = 64'(iint_ff) + prod;
      iint_sum = (iint_sum > I48_MAX) ? I48_MAX : ((iint_sum < I48_MIN) ? I48_MIN : iint_sum);
      iint_sum = clampsym(iint_sum, 64'(ilim_ff));
      // rpm/60 truncated toward zero via reciprocal of magnitude
      rpm_sc = 64'(rpm_ff) <<< FRACTION_BITS;
      mq = 64'(((rpm_sc < 0 ? -rpm_sc : rpm_sc) * 64'(RECIP60)) >>> RSH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         igain_ff <= '0;
         ogain_ff <= '0;
         olim_ff  <= '0;
         ilim_ff  <= '0;
         dlim_ff  <= '0;
         dband_ff <= '0;
         oerr_ff  <= '0;
         operr_ff <= '0;
         oint_ff  <= '0;
         ierr_ff  <= '0;
         iperr_ff <= '0;
         iint_ff  <= '0;
         dead_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LOOP_MODE:     mode_ff  <= csr_data[0];
               CSR_INNER_GAINS:   igain_ff <= csr_data[GAINS_WIDTH-1:0];
               CSR_OUTER_GAINS:   ogain_ff <= csr_data[GAINS_WIDTH-1:0];
               CSR_INNER_OUT_LIM: olim_ff  <= csr_data[LIMIT_WIDTH-1:0];
               CSR_INNER_INT_LIM: ilim_ff  <= csr_data[LIMIT_WIDTH-1:0];
               CSR_OUTER_DER_LIM: dlim_ff  <= csr_data[LIMIT_WIDTH-1:0];
               CSR_DEADBAND:      dband_ff <= csr_data[LIMIT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (cmd.load) dead_ff <= 1'b0;
         case (cmd.op)
            OP_SETUP: begin
               if (mode_ff) begin
                  operr_ff <= oerr_ff;
                  oerr_ff  <= 32'(oerr_sat);
               end
            end
            OP_OUTER_P: ;
            OP_OUTER_I: oint_ff <= 48'(oint_sum);
            OP_INNER_I: iint_ff <= 48'(iint_sum);
            OP_INNER_ERR: begin
               iperr_ff <= ierr_ff;
               ierr_ff  <= 32'(ierr_sat);
            end
            default: ;
         endcase
         if (cmd.op == OP_OUTER_P && abs_e < 64'(dband_ff)) dead_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sp_ff  <= speed_setpoint;
         pos_ff <= position_setpoint;
         ang_ff <= measured_angle;
         rpm_ff <= measured_rpm;
      end
      case (cmd.op)
         OP_SETUP: begin
            lim_ff    <= (sp64 < 0) ? ((sp64 == I32_MIN) ? 32'(I32_MAX) : 32'(-sp64))
                                    : sp_ff;
            target_ff <= sp_ff;
            meas_ff   <= (rpm_sc < 0) ? 32'(-mq) : 32'(mq);
            drive_ff  <= '0;
         end
         OP_OUTER_P: p_ff <= 42'(clampsym(prod, 64'(lim_ff)));
         OP_OUTER_D: d_ff <= 42'(clampsym(prod, 64'(dlim_ff)));
         OP_OUTER_SUM:
            target_ff <= 32'(clampsym(64'(p_ff) + 64'(oint_ff) + 64'(d_ff), 64'(lim_ff)));
         OP_INNER_P: p_ff <= 42'(prod);
         OP_INNER_D: d_ff <= 42'(prod);
         OP_INNER_SUM:
            drive_ff <= 32'(clampsym(64'(p_ff) + 64'(iint_ff) + 64'(d_ff), 64'(olim_ff)));
         default: ;
      endcase
   end

   always_comb begin
      status.cascade = mode_ff;
      status.dead    = (abs_e < 64'(dband_ff));
   end

   assign drive_value = dead_ff ? 32'sd0 : drive_ff;
   assign in_deadband = dead_ff;

   `ASSERT_IMPLY(a_dead_zero, clock, reset, in_deadband, drive_value == 32'sd0)
   `ASSERT_NEXT(a_load_clear, clock, reset, cmd.load, !in_deadband)
   `ASSERT_NEXT(a_err_shift, clock, reset, cmd.op == OP_INNER_ERR, iperr_ff == $past(ierr_ff))

endmodule
